### hw/rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants for the ALU with flags
// Operation codes, the flag register layout and the operand masks.
// ----------------------------------------------------------------------------
package cal_pkg;

   localparam int unsigned WordWidth = 16;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned OpWidth   = 4;

   localparam logic [15:0] Low12Mask  = 16'b0000111111111111;
   localparam logic [15:0] WordMask   = 16'hFFFF;
   localparam logic [3:0]  NibbleMask = 4'hF;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD     = 4'd0,
      OP_ADC     = 4'd1,
      OP_SUB     = 4'd2,
      OP_SBC     = 4'd3,
      OP_AND     = 4'd4,
      OP_OR      = 4'd5,
      OP_XOR     = 4'd6,
      OP_CP      = 4'd7,
      OP_INC     = 4'd8,
      OP_DEC     = 4'd9,
      OP_RLC     = 4'd10,
      OP_RL      = 4'd11,
      OP_RRC     = 4'd12,
      OP_RR      = 4'd13,
      OP_ADD16   = 4'd14,
      OP_ADD16SB = 4'd15
   } op_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

endpackage

### hw/rtl/cal_alu.sv
// ----------------------------------------------------------------------------
// cal_alu: combinational datapath of the ALU
// Computes the result and the new flags from one operation and the old flags.
// ----------------------------------------------------------------------------
module cal_alu (
   input  cal_pkg::op_type    op,
   input  logic [15:0]        a_value,
   input  logic [15:0]        b_value,
   input  cal_pkg::flags_type flags_old,
   output logic [15:0]        result,
   output cal_pkg::flags_type flags_new
);
   import cal_pkg::*;

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  hsum5;
   logic [8:0]  diff9;
   logic [4:0]  hdiff5;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic [16:0] sum17;
   logic [12:0] hsum13;
   logic [15:0] sext_b;
   logic [7:0]  byte_res;

   assign a8  = a_value[7:0];
   assign b8  = b_value[7:0];
   assign cin = ((op == OP_ADC) || (op == OP_SBC)) ? flags_old.c : 1'b0;

   assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
   assign hsum5  = {1'b0, a8[3:0] & NibbleMask} + {1'b0, b8[3:0] & NibbleMask}
                 + {4'd0, cin};
   // A negative difference shows as bit 8 (bit 4 for the nibble) set.
   assign diff9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
   assign hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
   assign inc8   = a8 + 8'd1;
   assign dec8   = a8 - 8'd1;
   assign sum17  = {1'b0, a_value & WordMask} + {1'b0, b_value & WordMask};
   assign hsum13 = {1'b0, a_value[11:0] & Low12Mask[11:0]}
                 + {1'b0, b_value[11:0] & Low12Mask[11:0]};
   assign sext_b = {{ByteWidth{b8[7]}}, b8};

   always_comb begin
      byte_res  = 8'd0;
      result    = 16'd0;
      flags_new = flags_old;
      case (op)
         OP_ADD, OP_ADC: begin
            byte_res  = sum9[7:0];
            flags_new = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            byte_res  = diff9[7:0];
            flags_new = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
         end
         OP_AND: begin
            byte_res  = a8 & b8;
            flags_new = '{z: ((a8 & b8) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_OR: begin
            byte_res  = a8 | b8;
            flags_new = '{z: ((a8 | b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_XOR: begin
            byte_res  = a8 ^ b8;
            flags_new = '{z: ((a8 ^ b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            byte_res  = inc8;
            flags_new = '{z: (inc8 == 8'd0), n: 1'b0, h: (inc8[3:0] == 4'd0),
                          c: flags_old.c};
         end
         OP_DEC: begin
            byte_res  = dec8;
            flags_new = '{z: (dec8 == 8'd0), n: 1'b1, h: (dec8[3:0] == NibbleMask),
                          c: flags_old.c};
         end
         OP_RLC, OP_RL: begin
            byte_res  = {a8[6:0], (op == OP_RLC) ? a8[7] : flags_old.c};
            flags_new = '{z: (byte_res == 8'd0), n: 1'b0, h: 1'b0, c: a8[7]};
         end
         OP_RRC, OP_RR: begin
            byte_res  = {(op == OP_RRC) ? a8[0] : flags_old.c, a8[7:1]};
            flags_new = '{z: (byte_res == 8'd0), n: 1'b0, h: 1'b0, c: a8[0]};
         end
         OP_ADD16: begin
            flags_new = '{z: flags_old.z, n: 1'b0, h: hsum13[12], c: sum17[16]};
         end
         default: begin
            flags_new = flags_old;
         end
      endcase

      case (op)
         OP_CP:      result = a_value;
         OP_ADD16:   result = sum17[15:0];
         OP_ADD16SB: result = a_value + sext_b;
         default:    result = {8'd0, byte_res};
      endcase
   end

endmodule

### hw/rtl/cpu_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_top: 8-bit ALU with 16-bit adds and Z, N, H and C flags
// Input register, combinational ALU, result register and flag register.
// ----------------------------------------------------------------------------
// One operation is accepted per cycle unless the input side stalls. Its
// result is offered on the result ports once it has moved from the input
// register into the result register. The flag register is updated as an
// operation leaves the input register for the result register, so
// back-to-back operations see the flags of the one before with no bubble.
// While a result is held, the input register can still take one more
// transfer; after that the input side stalls until the result is transferred.
// With the result side ready in every cycle, operations flow back to back.
module cpu_alu_with_flags_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_op,
   input  logic [15:0] req_a_value,
   input  logic [15:0] req_b_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result,
   output logic        rsp_zero_flag,
   output logic        rsp_subtract_flag,
   output logic        rsp_half_carry_flag,
   output logic        rsp_carry_flag
);
   import cal_pkg::*;

   logic        in_valid_ff;
   op_type      in_op_ff;
   logic [15:0] in_a_ff;
   logic [15:0] in_b_ff;
   logic        out_valid_ff;
   logic [15:0] out_result_ff;
   flags_type   flags_ff;
   flags_type   flags_in;
   logic [15:0] alu_result;
   logic        advance;

   cal_alu u_alu (
      .op        (in_op_ff),
      .a_value   (in_a_ff),
      .b_value   (in_b_ff),
      .flags_old (flags_ff),
      .result    (alu_result),
      .flags_new (flags_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         in_op_ff <= op_type'(req_op);
         in_a_ff  <= req_a_value;
         in_b_ff  <= req_b_value;
      end
      if (advance) begin
         out_result_ff <= alu_result;
      end
   end

   // The flag register always holds the flags of the operation in the
   // result register.
   assign rsp_valid           = out_valid_ff;
   assign rsp_result          = out_result_ff;
   assign rsp_zero_flag       = flags_ff.z;
   assign rsp_subtract_flag   = flags_ff.n;
   assign rsp_half_carry_flag = flags_ff.h;
   assign rsp_carry_flag      = flags_ff.c;

endmodule

### hw/rtl/cal_checker.sv
// ----------------------------------------------------------------------------
// cal_checker: port-level assertions for the ALU with flags
// Checks reset behaviour, result hold and input readiness over time.
// ----------------------------------------------------------------------------
module cal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_result,
   input logic        rsp_zero_flag,
   input logic        rsp_subtract_flag,
   input logic        rsp_half_carry_flag,
   input logic        rsp_carry_flag
);

   // No result is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A held result keeps its value and flags until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_zero_flag) && $stable(rsp_subtract_flag)
         && $stable(rsp_half_carry_flag) && $stable(rsp_carry_flag))
      else $error("held result changed");

   // With the result register empty the input side can never stall.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // A result transfer always frees room for a new input transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled during result transfer");

endmodule

bind cpu_alu_with_flags_top cal_checker u_cal_checker (.*);
